// ===== sv/periodic_task_timer_table_macros.svh =====
`ifndef PERIODIC_TASK_TIMER_TABLE_MACROS_SVH
`define PERIODIC_TASK_TIMER_TABLE_MACROS_SVH

// A same-cycle implication, checked on every rising clock edge outside reset.
`define PTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// An implication whose consequence is checked in the next cycle.
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ptt_pkg.sv =====
`timescale 1ns / 1ps
package ptt_pkg;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_SCHED  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_TICK_DONE = 3'd0,
    KIND_ADD_OK    = 3'd1,
    KIND_ADD_FULL  = 3'd2,
    KIND_DELETED   = 3'd3,
    KIND_DUE       = 3'd4,
    KIND_NONE_DUE  = 3'd5
  } kind_e;

  localparam int TaskW     = 8;
  localparam int FieldW    = 16;
  localparam int SlotW     = 3;
  localparam int PendW     = 8;
  localparam logic [PendW-1:0] PendMax = 8'd255;
  localparam int QueueDepth = 2;

  typedef struct packed {
    mode_e             mode;
    logic [TaskW-1:0]  task_id;
    logic [FieldW-1:0] start_delay;
    logic [FieldW-1:0] period;
    logic [SlotW-1:0]  slot;
    logic              slot_ok;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== sv/ptt_ram.sv =====
`timescale 1ns / 1ps
module ptt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ptt_front.sv =====
`timescale 1ns / 1ps
module ptt_front #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                        start_i,
  input  logic                        full_i,
  input  logic [1:0]                  mode_i,
  input  logic [ptt_pkg::TaskW-1:0]   task_id_i,
  input  logic [ptt_pkg::FieldW-1:0]  start_delay_i,
  input  logic [ptt_pkg::FieldW-1:0]  period_i,
  input  logic [ptt_pkg::SlotW-1:0]   slot_i,
  output logic                        push_o,
  output ptt_pkg::cmd_t               cmd_o
);

  // A word is taken whenever the command queue has room.
  assign push_o = start_i && !full_i;

  always_comb begin
    cmd_o.mode        = ptt_pkg::mode_e'(mode_i);
    cmd_o.task_id     = task_id_i;
    cmd_o.start_delay = start_delay_i;
    cmd_o.period      = period_i;
    cmd_o.slot        = slot_i;
    cmd_o.slot_ok     = (32'(slot_i) < NUM_SLOTS);
  end

endmodule

// ===== sv/ptt_cmd_fifo.sv =====
`timescale 1ns / 1ps
module ptt_cmd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ptt_pkg::cmd_t      cmd_i,
  input  logic               pop_i,
  output ptt_pkg::cmd_t      cmd_o,
  output ptt_pkg::q_status_t status_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ptt_pkg::cmd_t  mem_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o          = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == CW'(DEPTH));
  assign status_o.empty = (cnt_q == '0);

endmodule

// ===== sv/ptt_back.sv =====
`timescale 1ns / 1ps
module ptt_back #(
  parameter int NUM_SLOTS  = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  ptt_pkg::cmd_t              cmd_i,
  output logic                       pop_o,
  output logic                       strobe_o,
  output logic [2:0]                 kind_o,
  output logic [ptt_pkg::SlotW-1:0]  slot_out_o,
  output logic [ptt_pkg::TaskW-1:0]  due_task_o,
  output logic                       last_o
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TW = ptt_pkg::TaskW;
  localparam int PW = ptt_pkg::PendW;
  localparam int EW = TW + 2 * COUNT_BITS + PW;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_e;

  state_e                   state_q, state_d;
  ptt_pkg::mode_e           op_q, op_d;
  logic                     iss_q, iss_d;
  logic [IW-1:0]            rd_idx_q, rd_idx_d;
  logic                     pv_q, pv_d;
  logic [IW-1:0]            p_idx_q, p_idx_d;
  logic                     any_q, any_d;
  logic [NUM_SLOTS-1:0]     active_q, active_d;
  logic [NUM_SLOTS-1:0]     due_q, due_d;
  logic                     strobe_q, strobe_d;
  ptt_pkg::kind_e           kind_q, kind_d;
  logic [ptt_pkg::SlotW-1:0] slot_q, slot_d;
  logic [TW-1:0]            task_q, task_d;
  logic                     last_q, last_d;

  logic                     we;
  logic [IW-1:0]            waddr;
  logic [EW-1:0]            wdata;
  logic [EW-1:0]            rdata;

  logic [TW-1:0]            r_task;
  logic [COUNT_BITS-1:0]    r_delay;
  logic [COUNT_BITS-1:0]    r_period;
  logic [PW-1:0]            r_pend;
  logic [PW-1:0]            pend_dec;
  logic [COUNT_BITS-1:0]    add_delay;
  logic [COUNT_BITS-1:0]    add_period;
  logic [IW-1:0]            free_idx;
  logic                     free_found;
  logic                     later_due;
  logic                     p_is_last;

  ptt_ram #(
    .WIDTH(EW),
    .DEPTH(NUM_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(rd_idx_q),
    .rdata_o(rdata)
  );

  assign r_pend     = rdata[PW-1:0];
  assign r_period   = rdata[PW+COUNT_BITS-1:PW];
  assign r_delay    = rdata[PW+2*COUNT_BITS-1:PW+COUNT_BITS];
  assign r_task     = rdata[EW-1:EW-TW];
  assign pend_dec   = r_pend - 1'b1;
  assign add_delay  = COUNT_BITS'(32'(cmd_i.start_delay));
  assign add_period = COUNT_BITS'(32'(cmd_i.period));
  assign p_is_last  = (p_idx_q == IW'(NUM_SLOTS - 1));

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_idx   = IW'(i);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    later_due = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if ((i > int'(p_idx_q)) && due_q[i]) begin
        later_due = 1'b1;
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    iss_d    = iss_q;
    rd_idx_d = rd_idx_q;
    pv_d     = 1'b0;
    p_idx_d  = p_idx_q;
    any_d    = any_q;
    active_d = active_q;
    due_d    = due_q;
    strobe_d = 1'b0;
    kind_d   = kind_q;
    slot_d   = slot_q;
    task_d   = task_q;
    last_d   = last_q;
    pop_o    = 1'b0;
    we       = 1'b0;
    waddr    = p_idx_q;
    wdata    = rdata;

    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          op_d  = cmd_i.mode;
          case (cmd_i.mode)
            ptt_pkg::MODE_ADD: begin
              strobe_d = 1'b1;
              last_d   = 1'b1;
              task_d   = '0;
              if (free_found) begin
                we                 = 1'b1;
                waddr              = free_idx;
                wdata              = {cmd_i.task_id, add_delay, add_period, PW'(0)};
                active_d[free_idx] = (cmd_i.task_id != '0);
                due_d[free_idx]    = 1'b0;
                kind_d             = ptt_pkg::KIND_ADD_OK;
                slot_d             = ptt_pkg::SlotW'(free_idx);
              end else begin
                kind_d = ptt_pkg::KIND_ADD_FULL;
                slot_d = '0;
              end
            end
            ptt_pkg::MODE_DELETE: begin
              if (cmd_i.slot_ok) begin
                active_d[IW'(cmd_i.slot)] = 1'b0;
                due_d[IW'(cmd_i.slot)]    = 1'b0;
              end
              strobe_d = 1'b1;
              kind_d   = ptt_pkg::KIND_DELETED;
              slot_d   = cmd_i.slot;
              task_d   = '0;
              last_d   = 1'b1;
            end
            ptt_pkg::MODE_TICK, ptt_pkg::MODE_SCHED: begin
              state_d  = S_WALK;
              iss_d    = 1'b1;
              rd_idx_d = '0;
              any_d    = 1'b0;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_WALK: begin
        // One slot read is issued per cycle; its data is handled in the next cycle.
        if (iss_q) begin
          pv_d    = 1'b1;
          p_idx_d = rd_idx_q;
          if (rd_idx_q == IW'(NUM_SLOTS - 1)) begin
            iss_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end

        if (pv_q) begin
          if (op_q == ptt_pkg::MODE_TICK) begin
            if (active_q[p_idx_q]) begin
              we = 1'b1;
              if (r_delay == '0) begin
                wdata = {r_task, r_period, r_period,
                         (r_pend == ptt_pkg::PendMax) ? r_pend : r_pend + 1'b1};
                due_d[p_idx_q] = 1'b1;
              end else begin
                wdata = {r_task, r_delay - 1'b1, r_period, r_pend};
              end
            end
            if (p_is_last) begin
              state_d  = S_IDLE;
              strobe_d = 1'b1;
              kind_d   = ptt_pkg::KIND_TICK_DONE;
              slot_d   = '0;
              task_d   = '0;
              last_d   = 1'b1;
            end
          end else begin
            if (due_q[p_idx_q]) begin
              strobe_d = 1'b1;
              kind_d   = ptt_pkg::KIND_DUE;
              slot_d   = ptt_pkg::SlotW'(p_idx_q);
              task_d   = r_task;
              last_d   = !later_due;
              any_d    = 1'b1;
              if (r_period == '0) begin
                active_d[p_idx_q] = 1'b0;
                due_d[p_idx_q]    = 1'b0;
              end else begin
                we             = 1'b1;
                wdata          = {r_task, r_delay, r_period, pend_dec};
                due_d[p_idx_q] = (pend_dec != '0);
              end
            end
            if (p_is_last) begin
              state_d = S_IDLE;
              if (!any_q && !due_q[p_idx_q]) begin
                strobe_d = 1'b1;
                kind_d   = ptt_pkg::KIND_NONE_DUE;
                slot_d   = '0;
                task_d   = '0;
                last_d   = 1'b1;
              end
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= ptt_pkg::MODE_TICK;
      iss_q    <= 1'b0;
      rd_idx_q <= '0;
      pv_q     <= 1'b0;
      p_idx_q  <= '0;
      any_q    <= 1'b0;
      active_q <= '0;
      due_q    <= '0;
      strobe_q <= 1'b0;
      kind_q   <= ptt_pkg::KIND_TICK_DONE;
      slot_q   <= '0;
      task_q   <= '0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      iss_q    <= iss_d;
      rd_idx_q <= rd_idx_d;
      pv_q     <= pv_d;
      p_idx_q  <= p_idx_d;
      any_q    <= any_d;
      active_q <= active_d;
      due_q    <= due_d;
      strobe_q <= strobe_d;
      kind_q   <= kind_d;
      slot_q   <= slot_d;
      task_q   <= task_d;
      last_q   <= last_d;
    end
  end

  assign strobe_o   = strobe_q;
  assign kind_o     = kind_q;
  assign slot_out_o = slot_q;
  assign due_task_o = task_q;
  assign last_o     = last_q;

endmodule

// ===== sv/periodic_task_timer_table.sv =====
`timescale 1ns / 1ps
`include "periodic_task_timer_table_macros.svh"
// A table of NUM_SLOTS software timer slots driven by command words.
// A command word is taken at a rising edge where start is high and busy is
// low; mode selects tick, add task, delete slot or schedule pass.
// Taken words wait in a two-entry command queue, and busy is high while it
// is full, so the front keeps taking words while the back end works.
// Each result word is shown for one cycle with strobe_o high; last_o marks
// the final word of a command. The receiver cannot hold results off.
// An add or delete is finished by the back end in its idle state; the word
// passes through the command queue and its result is registered for output.
// A tick or schedule pass walks the slot memory one slot per cycle through
// its registered read port, and it holds the back end until the walk has
// handled the last slot.
// A schedule pass gives one word per due slot, in slot order, as the walk
// reaches it, or a single "none due" word at the end of the walk.
// Reset clears the queue, the per-slot active and due flags and the result
// strobe; all slots read as free after reset without touching the memory.
module periodic_task_timer_table #(
  parameter int NUM_SLOTS  = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  mode_i,
  input  logic [ptt_pkg::TaskW-1:0]   task_id_i,
  input  logic [ptt_pkg::FieldW-1:0]  start_delay_i,
  input  logic [ptt_pkg::FieldW-1:0]  period_i,
  input  logic [ptt_pkg::SlotW-1:0]   slot_i,
  output logic                        strobe_o,
  output logic [2:0]                  kind_o,
  output logic [ptt_pkg::SlotW-1:0]   slot_out_o,
  output logic [ptt_pkg::TaskW-1:0]   due_task_o,
  output logic                        last_o
);

  logic               push;
  logic               pop;
  ptt_pkg::cmd_t      cmd_in;
  ptt_pkg::cmd_t      cmd_head;
  ptt_pkg::q_status_t q_status;

  ptt_front #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_front (
    .start_i      (start),
    .full_i       (q_status.full),
    .mode_i       (mode_i),
    .task_id_i    (task_id_i),
    .start_delay_i(start_delay_i),
    .period_i     (period_i),
    .slot_i       (slot_i),
    .push_o       (push),
    .cmd_o        (cmd_in)
  );

  ptt_cmd_fifo #(
    .DEPTH(ptt_pkg::QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .cmd_o   (cmd_head),
    .status_o(q_status)
  );

  ptt_back #(
    .NUM_SLOTS (NUM_SLOTS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (q_status.empty),
    .cmd_i     (cmd_head),
    .pop_o     (pop),
    .strobe_o  (strobe_o),
    .kind_o    (kind_o),
    .slot_out_o(slot_out_o),
    .due_task_o(due_task_o),
    .last_o    (last_o)
  );

  assign busy = q_status.full;

  `PTT_ASSERT_NOW(tick_result_a, strobe_o && kind_o == ptt_pkg::KIND_TICK_DONE, last_o && slot_out_o == '0 && due_task_o == '0, "Tick result is malformed.")
  `PTT_ASSERT_NOW(only_due_open_a, strobe_o && kind_o != ptt_pkg::KIND_DUE, last_o, "A result other than a due task is not final.")
  `PTT_ASSERT_NEXT(taken_queued_a, start && !busy, !q_status.empty, "A taken command word did not reach the queue.")

endmodule

// ===== tb/periodic_task_timer_table_checker.sv =====
`timescale 1ns / 1ps
module periodic_task_timer_table_checker #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic [1:0]                 mode_i,
  input  logic [ptt_pkg::TaskW-1:0]  task_id_i,
  input  logic [ptt_pkg::FieldW-1:0] start_delay_i,
  input  logic [ptt_pkg::FieldW-1:0] period_i,
  input  logic [ptt_pkg::SlotW-1:0]  slot_i,
  input  logic                       strobe_i,
  input  logic [2:0]                 kind_i,
  input  logic [ptt_pkg::SlotW-1:0]  slot_out_i,
  input  logic [ptt_pkg::TaskW-1:0]  due_task_i,
  input  logic                       last_i,
  output int                         err_count_o,
  output int                         outstanding_o
);
  import ptt_pkg::*;

  typedef struct packed {
    kind_e            kind;
    logic [SlotW-1:0] slot;
    logic [TaskW-1:0] due_task;
    logic             last;
  } answer_t;

  logic [TaskW-1:0]  slot_owner [NUM_SLOTS];
  logic [FieldW-1:0] slot_count [NUM_SLOTS];
  logic [FieldW-1:0] slot_reload[NUM_SLOTS];
  logic [PendW-1:0]  slot_runs  [NUM_SLOTS];

  answer_t table_answers[$];
  answer_t seen;
  int      errors;

  function automatic answer_t make_answer(kind_e k, int s, logic [TaskW-1:0] t, logic l);
    answer_t a;
    a.kind = k;
    a.slot = SlotW'(s);
    a.due_task = t;
    a.last = l;
    return a;
  endfunction

  task automatic free_slot(int i);
    slot_owner[i] = '0;
    slot_count[i] = '0;
    slot_reload[i] = '0;
    slot_runs[i] = '0;
  endtask

  task automatic advance_table(mode_e m, logic [TaskW-1:0] tid, logic [FieldW-1:0] dly,
                               logic [FieldW-1:0] per, logic [SlotW-1:0] sl);
    bit granted;
    int final_due;
    case (m)
      MODE_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_owner[i] != '0) begin
            if (slot_count[i] == '0) begin
              if (slot_runs[i] != PendMax) slot_runs[i] = slot_runs[i] + 1'b1;
              if (slot_reload[i] != '0) slot_count[i] = slot_reload[i];
            end else begin
              slot_count[i] = slot_count[i] - 1'b1;
            end
          end
        end
        table_answers.push_back(make_answer(KIND_TICK_DONE, 0, '0, 1'b1));
      end
      MODE_ADD: begin
        granted = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!granted && slot_owner[i] == '0) begin
            granted = 1'b1;
            slot_owner[i] = tid;
            slot_count[i] = dly;
            slot_reload[i] = per;
            slot_runs[i] = '0;
            table_answers.push_back(make_answer(KIND_ADD_OK, i, '0, 1'b1));
          end
        end
        if (!granted) table_answers.push_back(make_answer(KIND_ADD_FULL, 0, '0, 1'b1));
      end
      MODE_DELETE: begin
        if (int'(sl) < NUM_SLOTS) free_slot(int'(sl));
        table_answers.push_back(make_answer(KIND_DELETED, int'(sl), '0, 1'b1));
      end
      default: begin
        final_due = -1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_runs[i] != '0 && slot_owner[i] != '0) final_due = i;
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_runs[i] != '0 && slot_owner[i] != '0) begin
            table_answers.push_back(make_answer(KIND_DUE, i, slot_owner[i], i == final_due));
            slot_runs[i] = slot_runs[i] - 1'b1;
            if (slot_reload[i] == '0) free_slot(i);
          end
        end
        if (final_due < 0) table_answers.push_back(make_answer(KIND_NONE_DUE, 0, '0, 1'b1));
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) free_slot(i);
      table_answers.delete();
    end else begin
      if (start_i && !busy_i) begin
        advance_table(mode_e'(mode_i), task_id_i, start_delay_i, period_i, slot_i);
      end
      if (strobe_i) begin
        if (table_answers.size() == 0) begin
          $error("unexpected result word: kind %0d slot %0d task %0d last %0d",
                 kind_i, slot_out_i, due_task_i, last_i);
          errors++;
        end else begin
          seen = table_answers.pop_front();
          if (kind_i !== seen.kind) begin
            $error("kind: expected %0d, actual %0d", seen.kind, kind_i);
            errors++;
          end
          if (slot_out_i !== seen.slot) begin
            $error("slot_out: expected %0d, actual %0d", seen.slot, slot_out_i);
            errors++;
          end
          if (due_task_i !== seen.due_task) begin
            $error("due_task: expected %0d, actual %0d", seen.due_task, due_task_i);
            errors++;
          end
          if (last_i !== seen.last) begin
            $error("last: expected %0d, actual %0d", seen.last, last_i);
            errors++;
          end
        end
      end
    end
    err_count_o <= errors;
    outstanding_o <= table_answers.size();
  end

endmodule

// ===== tb/periodic_task_timer_table_tb.sv =====
`timescale 1ns / 1ps
module periodic_task_timer_table_tb;
  import ptt_pkg::*;

  localparam int NUM_SLOTS = 8;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         mode_i = '0;
  logic [TaskW-1:0]   task_id_i = '0;
  logic [FieldW-1:0]  start_delay_i = '0;
  logic [FieldW-1:0]  period_i = '0;
  logic [SlotW-1:0]   slot_i = '0;
  logic               strobe_o;
  logic [2:0]         kind_o;
  logic [SlotW-1:0]   slot_out_o;
  logic [TaskW-1:0]   due_task_o;
  logic               last_o;
  int                 err_count;
  int                 outstanding;
  bit                 steady = 1'b0;

  always #5 clk_i = ~clk_i;

  periodic_task_timer_table #(
    .NUM_SLOTS (NUM_SLOTS),
    .COUNT_BITS(FieldW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .task_id_i    (task_id_i),
    .start_delay_i(start_delay_i),
    .period_i     (period_i),
    .slot_i       (slot_i),
    .strobe_o     (strobe_o),
    .kind_o       (kind_o),
    .slot_out_o   (slot_out_o),
    .due_task_o   (due_task_o),
    .last_o       (last_o)
  );

  periodic_task_timer_table_checker #(
    .NUM_SLOTS(NUM_SLOTS)
  ) table_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .mode_i       (mode_i),
    .task_id_i    (task_id_i),
    .start_delay_i(start_delay_i),
    .period_i     (period_i),
    .slot_i       (slot_i),
    .strobe_i     (strobe_o),
    .kind_i       (kind_o),
    .slot_out_i   (slot_out_o),
    .due_task_i   (due_task_o),
    .last_i       (last_o),
    .err_count_o  (err_count),
    .outstanding_o(outstanding)
  );

  task automatic send_word(mode_e m, logic [TaskW-1:0] tid, logic [FieldW-1:0] dly,
                           logic [FieldW-1:0] per, logic [SlotW-1:0] sl);
    @(negedge clk_i);
    start <= 1'b1;
    mode_i <= m;
    task_id_i <= tid;
    start_delay_i <= dly;
    period_i <= per;
    slot_i <= sl;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic pause_sender();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (steady || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 40);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain_table();
    @(negedge clk_i);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  function automatic logic [FieldW-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return FieldW'($urandom_range(0, 7));
    if (r < 90) return FieldW'($urandom_range(8, 40));
    return FieldW'($urandom_range(0, 65535));
  endfunction

  task automatic random_word();
    int r;
    mode_e m;
    logic [TaskW-1:0] tid;
    logic [FieldW-1:0] dly;
    logic [FieldW-1:0] per;
    logic [SlotW-1:0] sl;
    r = $urandom_range(0, 99);
    tid = TaskW'($urandom_range(1, 255));
    dly = pick_count();
    per = pick_count();
    sl = SlotW'($urandom_range(0, NUM_SLOTS - 1));
    if (r < 10) begin
      m = mode_e'($urandom_range(0, 3));
      tid = TaskW'($urandom);
      dly = FieldW'($urandom);
      per = FieldW'($urandom);
    end else if (r < 50) begin
      m = MODE_TICK;
    end else if (r < 68) begin
      m = MODE_ADD;
    end else if (r < 80) begin
      m = MODE_DELETE;
    end else begin
      m = MODE_SCHED;
    end
    send_word(m, tid, dly, per, sl);
  endtask

  initial begin
    #5_000_000;
    $display("periodic_task_timer_table_tb: done, errors");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_word(MODE_SCHED, '0, '0, '0, '0);
    pause_sender();
    send_word(MODE_TICK, '0, '0, '0, '0);
    pause_sender();
    send_word(MODE_ADD, 8'd255, 16'd0, 16'd0, '0);
    pause_sender();
    // An add with a zero id is granted but leaves the slot free.
    send_word(MODE_ADD, 8'd0, 16'd5, 16'd5, '0);
    pause_sender();
    send_word(MODE_ADD, 8'd1, 16'hffff, 16'hffff, '0);
    pause_sender();
    send_word(MODE_TICK, '0, '0, '0, '0);
    send_word(MODE_TICK, '0, '0, '0, '0);
    pause_sender();
    send_word(MODE_SCHED, '0, '0, '0, '0);
    send_word(MODE_SCHED, '0, '0, '0, '0);
    for (int i = 2; i <= 9; i++) begin
      pause_sender();
      send_word(MODE_ADD, TaskW'(i), 16'd0, 16'd1, '0);
    end
    send_word(MODE_TICK, '0, '0, '0, '0);
    pause_sender();
    send_word(MODE_SCHED, '0, '0, '0, '0);
    pause_sender();
    send_word(MODE_DELETE, '0, '0, '0, 3'd7);
    send_word(MODE_DELETE, '0, '0, '0, 3'd7);
    pause_sender();
    send_word(MODE_DELETE, '0, '0, '0, 3'd0);
    send_word(MODE_DELETE, '0, '0, '0, 3'd2);
    pause_sender();
    send_word(MODE_TICK, 8'hff, 16'hffff, 16'hffff, 3'd7);
    send_word(MODE_ADD, 8'haa, 16'h5555, 16'haaaa, 3'd5);
    pause_sender();
    send_word(MODE_ADD, 8'h3c, 16'd0, 16'd1, '0);

    // A run of back-to-back ticks that builds up pending runs on the period-one slots.
    steady = 1'b1;
    repeat (40) send_word(MODE_TICK, '0, '0, '0, '0);
    steady = 1'b0;
    repeat (20) begin
      pause_sender();
      send_word(MODE_SCHED, '0, '0, '0, '0);
    end
    drain_table();

    for (int n = 0; n < 300; n++) begin
      steady = (n >= 120 && n < 180);
      if (n == 80 || n == 240) drain_table();
      pause_sender();
      random_word();
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4 * NUM_SLOTS) @(posedge clk_i);
    if (err_count == 0) begin
      $display("periodic_task_timer_table_tb: done, clean");
    end else begin
      $display("periodic_task_timer_table_tb: done, errors");
    end
    $finish;
  end

endmodule
